// ===== design/mqg_pkg.sv =====
// shared types, register map and gray table for the mouse quadrature generator
package mqg_pkg;

    // field widths
    localparam int DELTA_W = 11;
    localparam int PEND_W  = 13;
    localparam int SCALE_W = 3;
    localparam int LIMIT_W = 12;
    localparam int LINES_W = 5;

    // register reset values
    localparam logic [SCALE_W-1:0] SCALE_RESET = 3'd2;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 12'd640;

    // register map, selected by paddr[2]
    localparam logic REG_SCALE = 1'b0;
    localparam logic REG_LIMIT = 1'b1;

    // configuration values seen by the datapath
    typedef struct packed {
        logic [SCALE_W-1:0] scale;
        logic [LIMIT_W-1:0] limit;
    } t_cfg;

    // which way an axis moved on this tick
    typedef enum logic [1:0] {
        STEP_NONE = 2'd0,
        STEP_POS  = 2'd1,
        STEP_NEG  = 2'd2
    } t_step;

    // phase to A/B lines, sequence 0,1,3,2
    function automatic logic [1:0] gray_of(input logic [1:0] phase);
        logic [1:0] g;
        case (phase)
            2'd0:    g = 2'h0;
            2'd1:    g = 2'h1;
            2'd2:    g = 2'h3;
            default: g = 2'h2;
        endcase
        return g;
    endfunction

endpackage

// ===== design/mouse_quadrature_generator_unit.sv =====
// Mouse quadrature generator top level: tick input register, axis update and line output register.
// Takes one tick transfer per clock while the output side is not stalled. A tick passes through
// an input register and then, once the output side has room, updates both axes and the output
// register; a result transfer carrying the five lines is then offered from the output register,
// and only when the lines change (always for the first tick after reset). The axis update reads
// and writes the pending counts and phases in the same cycle. Registers: motion_scale at 0x0,
// pending_limit at 0x4; write them only while no tick is in flight.
module mouse_quadrature_generator_unit
    import mqg_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // tick input
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // host_dx[10:0], host_dy[21:11], host_button[22], zero
    // line output
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // x_line_a, x_line_b, y_line_a, y_line_b, button_line, zero
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    t_cfg                      w_cfg;

    logic                      r_in_valid;
    logic signed [DELTA_W-1:0] r_in_dx;
    logic signed [DELTA_W-1:0] r_in_dy;
    logic                      r_in_button;

    logic signed [PEND_W-1:0]  r_pend_x;
    logic signed [PEND_W-1:0]  r_pend_y;
    logic [1:0]                r_phase_x;
    logic [1:0]                r_phase_y;
    logic [LINES_W-1:0]        r_last;
    logic                      r_known;

    logic                      r_out_valid;
    logic [LINES_W-1:0]        r_out_lines;

    logic signed [PEND_W-1:0]  n_pend_x;
    logic signed [PEND_W-1:0]  n_pend_y;
    logic [1:0]                n_phase_x;
    logic [1:0]                n_phase_y;
    t_step                     w_step_x;
    t_step                     w_step_y;
    logic [LINES_W-1:0]        w_lines;
    logic                      w_emit;
    logic                      w_proc;
    logic                      w_in_fire;

    mqg_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // handshake: the tick in the input register is processed when the output side has room
    assign w_proc        = r_in_valid & (~r_out_valid | m_axis_tready);
    assign s_axis_tready = ~r_in_valid | w_proc;
    assign w_in_fire     = s_axis_tvalid & s_axis_tready;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_in_dx     <= s_axis_tdata[10:0];
            r_in_dy     <= s_axis_tdata[21:11];
            r_in_button <= s_axis_tdata[22];
        end
    end

    mqg_axis u_axis_x (
        .i_pend  (r_pend_x),
        .i_delta (r_in_dx),
        .i_cfg   (w_cfg),
        .o_pend  (n_pend_x),
        .o_step  (w_step_x)
    );

    mqg_axis u_axis_y (
        .i_pend  (r_pend_y),
        .i_delta (r_in_dy),
        .i_cfg   (w_cfg),
        .o_pend  (n_pend_y),
        .o_step  (w_step_y)
    );

    // phase update: x counts down on positive motion, y counts up
    always_comb begin
        case (w_step_x)
            STEP_POS: n_phase_x = r_phase_x - 2'd1;
            STEP_NEG: n_phase_x = r_phase_x + 2'd1;
            default:  n_phase_x = r_phase_x;
        endcase
        case (w_step_y)
            STEP_POS: n_phase_y = r_phase_y + 2'd1;
            STEP_NEG: n_phase_y = r_phase_y - 2'd1;
            default:  n_phase_y = r_phase_y;
        endcase
    end

    // line pattern and change detect
    assign w_lines = {r_in_button, gray_of(n_phase_y), gray_of(n_phase_x)};
    assign w_emit  = ~r_known | (w_lines != r_last);

    // axis state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_x  <= '0;
            r_pend_y  <= '0;
            r_phase_x <= '0;
            r_phase_y <= '0;
            r_last    <= '0;
            r_known   <= 1'b0;
        end else if (w_proc) begin
            r_pend_x  <= n_pend_x;
            r_pend_y  <= n_pend_y;
            r_phase_x <= n_phase_x;
            r_phase_y <= n_phase_y;
            r_known   <= 1'b1;
            if (w_emit) begin
                r_last <= w_lines;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_proc) begin
            r_out_valid <= w_emit;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_proc && w_emit) begin
            r_out_lines <= w_lines;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = 8'(r_out_lines);

    // a stalled tick in the input register is never lost or overwritten
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !w_proc |=> r_in_valid && $stable(r_in_dx) && $stable(r_in_dy))
        else $error("input register lost a stalled tick");

    // every emitted line pattern becomes the remembered pattern
    a_last_tracks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_proc && w_emit |=> r_last == r_out_lines && r_out_valid)
        else $error("last lines not updated with emitted result");

    // a processed tick with unchanged lines gives no result
    a_no_repeat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_proc && !w_emit |=> !r_out_valid)
        else $error("result given for unchanged lines");

    // x phase moves at most one step per tick
    a_phase_x_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_proc |=> (r_phase_x == $past(r_phase_x))
                || (r_phase_x == 2'($past(r_phase_x) + 2'd1))
                || (r_phase_x == 2'($past(r_phase_x) - 2'd1)))
        else $error("x phase jumped by more than one step");

    // after any processed tick the first-result flag is set
    a_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_proc |=> r_known)
        else $error("first-result flag not set after a tick");

endmodule

// ===== design/mqg_cfg.sv =====
// apb register file holding motion scale and pending limit
module mqg_cfg
    import mqg_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output t_cfg        o_cfg
);

    logic [SCALE_W-1:0] r_scale;
    logic [LIMIT_W-1:0] r_limit;
    logic               w_wr;
    logic               w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel & penable & pwrite;
    assign w_idx  = paddr[2];

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale <= SCALE_RESET;
            r_limit <= LIMIT_RESET;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_SCALE: r_scale <= pwdata[SCALE_W-1:0];
                REG_LIMIT: r_limit <= pwdata[LIMIT_W-1:0];
                default:   r_scale <= r_scale;
            endcase
        end
    end

    // read mux
    always_comb begin
        unique case (w_idx)
            REG_SCALE: prdata = 32'(r_scale);
            REG_LIMIT: prdata = 32'(r_limit);
            default:   prdata = '0;
        endcase
    end

    assign o_cfg.scale = r_scale;
    assign o_cfg.limit = r_limit;

endmodule

// ===== design/mqg_axis.sv =====
// one axis: scale, accumulate, clamp and single unit step toward zero
module mqg_axis
    import mqg_pkg::*;
(
    input  logic signed [PEND_W-1:0]  i_pend,
    input  logic signed [DELTA_W-1:0] i_delta,
    input  t_cfg                      i_cfg,
    output logic signed [PEND_W-1:0]  o_pend,
    output t_step                     o_step
);

    logic signed [13:0]       w_scale;
    logic signed [13:0]       w_prod;
    logic signed [14:0]       w_sum;
    logic signed [14:0]       w_lim;
    logic signed [14:0]       w_clamp;
    logic signed [PEND_W-1:0] w_pend;

    // scaled delta, product fits 14 bits signed
    assign w_scale = signed'(14'({1'b0, i_cfg.scale}));
    assign w_prod  = 14'(i_delta) * w_scale;
    assign w_sum   = 15'(i_pend) + 15'(w_prod);
    assign w_lim   = signed'(15'({1'b0, i_cfg.limit}));

    // saturate to +/- limit
    always_comb begin
        if (w_sum > w_lim) begin
            w_clamp = w_lim;
        end else if (w_sum < -w_lim) begin
            w_clamp = -w_lim;
        end else begin
            w_clamp = w_sum;
        end
    end

    assign w_pend = w_clamp[PEND_W-1:0];

    // move one unit toward zero
    always_comb begin
        if (w_pend > 0) begin
            o_pend = w_pend - 13'sd1;
            o_step = STEP_POS;
        end else if (w_pend < 0) begin
            o_pend = w_pend + 13'sd1;
            o_step = STEP_NEG;
        end else begin
            o_pend = w_pend;
            o_step = STEP_NONE;
        end
    end

endmodule
